// ----- sv/fhau_pkg.sv -----
// ============================================================================
// fhau_pkg
// Shared widths, codes, result structs and count helpers for the flash
// hierarchical address unit.
// ============================================================================
package fhau_pkg;

    localparam int LIN_W = 40;   // flat page number
    localparam int CNT_W = 17;   // widest geometry count
    localparam int LVL_W = 3;

    localparam logic [CNT_W-1:0] MAX_PAGES_PER_BLOCK  = 17'd1024;
    localparam logic [CNT_W-1:0] MAX_BLOCKS_PER_PLANE = 17'd65536;
    localparam logic [CNT_W-1:0] MAX_PLANES_PER_DIE   = 17'd16;
    localparam logic [CNT_W-1:0] MAX_DIES_PER_PACKAGE = 17'd16;
    localparam logic [CNT_W-1:0] MAX_PACKAGES         = 17'd64;

    localparam logic [1:0] OP_LOAD_LINEAR = 2'd0;
    localparam logic [1:0] OP_LOAD_FIELDS = 2'd1;
    localparam logic [1:0] OP_READ_LINEAR = 2'd2;
    localparam logic [1:0] OP_COMPARE     = 2'd3;

    localparam logic [LVL_W-1:0] LVL_NONE    = 3'd0;
    localparam logic [LVL_W-1:0] LVL_PACKAGE = 3'd1;
    localparam logic [LVL_W-1:0] LVL_DIE     = 3'd2;
    localparam logic [LVL_W-1:0] LVL_PLANE   = 3'd3;
    localparam logic [LVL_W-1:0] LVL_BLOCK   = 3'd4;
    localparam logic [LVL_W-1:0] LVL_PAGE    = 3'd5;

    localparam logic [2:0] REG_PAGES_PER_BLOCK  = 3'd0;
    localparam logic [2:0] REG_BLOCKS_PER_PLANE = 3'd1;
    localparam logic [2:0] REG_PLANES_PER_DIE   = 3'd2;
    localparam logic [2:0] REG_DIES_PER_PACKAGE = 3'd3;
    localparam logic [2:0] REG_PACKAGES         = 3'd4;

    typedef struct packed {
        logic             done;
        logic [LIN_W-1:0] quotient;
        logic [CNT_W-1:0] remainder;
    } t_div_out;

    typedef struct packed {
        logic             done;
        logic [LIN_W-1:0] result;
    } t_mul_out;

    // zero reads as one, oversize saturates
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] maxv);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [LVL_W-1:0] clamp_level(input logic [LVL_W-1:0] lv);
        logic [LVL_W-1:0] r;
        r = (lv > LVL_PAGE) ? LVL_PAGE : lv;
        return r;
    endfunction

endpackage

// ----- sv/fhau_divider.sv -----
// ============================================================================
// fhau_divider
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ============================================================================
module fhau_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fhau_pkg::LIN_W-1:0]  i_dividend,
    input  logic [fhau_pkg::CNT_W-1:0]  i_divisor,
    output fhau_pkg::t_div_out          o_res
);

    localparam int CW = $clog2(fhau_pkg::LIN_W);
    localparam logic [CW-1:0] LAST = CW'(fhau_pkg::LIN_W - 1);

    logic [fhau_pkg::LIN_W-1:0] r_quo;
    logic [fhau_pkg::CNT_W-1:0] r_rem;
    logic [fhau_pkg::CNT_W-1:0] r_dsr;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [fhau_pkg::CNT_W:0]   rem_sh;
    logic [fhau_pkg::CNT_W:0]   diff;
    logic                       ge;
    logic [fhau_pkg::CNT_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_quo[fhau_pkg::LIN_W-1]};
        diff   = rem_sh - {1'b0, r_dsr};
        ge     = (rem_sh >= {1'b0, r_dsr});
        // remainder stays below the divisor, so the top bit is always clear
        n_rem  = ge ? diff[fhau_pkg::CNT_W-1:0] : rem_sh[fhau_pkg::CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_quo <= {r_quo[fhau_pkg::LIN_W-2:0], ge};
                r_rem <= n_rem;
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

// ----- sv/fhau_multiplier.sv -----
// ============================================================================
// fhau_multiplier
// Bit-serial shift-add multiply-accumulate: result = mcand * mult + addend,
// wrapped to the flat address width. One multiplier bit per cycle, LSB first.
// ============================================================================
module fhau_multiplier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fhau_pkg::LIN_W-1:0]  i_mcand,
    input  logic [fhau_pkg::CNT_W-1:0]  i_mult,
    input  logic [15:0]                 i_addend,
    output fhau_pkg::t_mul_out          o_res
);

    localparam int CW = $clog2(fhau_pkg::CNT_W);
    localparam logic [CW-1:0] LAST = CW'(fhau_pkg::CNT_W - 1);

    logic [fhau_pkg::LIN_W-1:0] r_p;
    logic [fhau_pkg::LIN_W-1:0] r_mc;
    logic [fhau_pkg::CNT_W-1:0] r_ml;
    logic [CW-1:0]              r_cnt;
    logic                       r_busy;
    logic                       r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_p    <= fhau_pkg::LIN_W'(i_addend);
                r_mc   <= i_mcand;
                r_ml   <= i_mult;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_ml[0]) begin
                    r_p <= r_p + r_mc;
                end
                r_mc  <= {r_mc[fhau_pkg::LIN_W-2:0], 1'b0};
                r_ml  <= {1'b0, r_ml[fhau_pkg::CNT_W-1:1]};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done   = r_done;
    assign o_res.result = r_p;

endmodule

// ----- sv/flash_hierarchical_address_unit.sv -----
// ============================================================================
// flash_hierarchical_address_unit
// Holds one flash physical address and converts between flat page numbers
// and package/die/plane/block/page fields.
// ============================================================================
// Usage:
//  - Input channel (i_in_valid/o_in_ready) takes one operation per
//    transaction: load linear, load fields, read linear or compare.
//  - Output channel (o_out_valid/i_out_ready) returns one transaction per
//    operation: the stored address, its composed flat number and the match
//    level (nonzero only on compare).
//  - Config port (i_cfg_we/i_cfg_idx/i_cfg_data) writes the geometry counts;
//    write only while no operation is in flight.
//  - Load linear runs five divisions, one bit per cycle on a shared 40-step
//    restoring divider, then composition.
//  - Composition runs four multiply-adds on a 17-step shift-add multiplier
//    for every operation.
//  - One operation at a time; the next one is accepted as soon as the
//    result is in the output register, even while the receiver stalls.
//  - A stalled receiver holds the result; a finished operation waits until
//    the output register is free.
//  - Reset (synchronous, active low) clears the stored address to level
//    none and restores the default geometry counts.
// ============================================================================
module flash_hierarchical_address_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [39:0] i_linear_address,
    input  logic [2:0]  i_level,
    input  logic [5:0]  i_package_in,
    input  logic [3:0]  i_die_in,
    input  logic [3:0]  i_plane_in,
    input  logic [15:0] i_block_in,
    input  logic [9:0]  i_page_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_package_out,
    output logic [3:0]  o_die_out,
    output logic [3:0]  o_plane_out,
    output logic [15:0] o_block_out,
    output logic [9:0]  o_page_out,
    output logic [2:0]  o_level_out,
    output logic [39:0] o_composed_address,
    output logic [2:0]  o_match_level
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MINIT = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [2:0] DIV_LAST = 3'd4;
    localparam logic [2:0] MUL_LAST = 3'd3;

    // geometry registers
    logic [10:0] r_pages_per_block;
    logic [16:0] r_blocks_per_plane;
    logic [4:0]  r_planes_per_die;
    logic [4:0]  r_dies_per_package;
    logic [6:0]  r_packages_per_drive;

    // stored address
    logic [5:0]  r_held_package;
    logic [3:0]  r_held_die;
    logic [3:0]  r_held_plane;
    logic [15:0] r_held_block;
    logic [9:0]  r_held_page;
    logic [2:0]  r_held_level;

    logic [2:0]  r_state;
    logic [2:0]  r_stage;
    logic        r_div_start;
    logic        r_mul_start;
    logic [39:0] r_lin;
    logic [2:0]  r_lvl;
    logic [2:0]  r_match;
    logic [39:0] r_acc;

    logic        r_out_valid;
    logic [5:0]  r_out_package;
    logic [3:0]  r_out_die;
    logic [3:0]  r_out_plane;
    logic [15:0] r_out_block;
    logic [9:0]  r_out_page;
    logic [2:0]  r_out_level;
    logic [39:0] r_out_addr;
    logic [2:0]  r_out_match;

    logic [fhau_pkg::CNT_W-1:0] np, nb, nl, nd, nk;
    logic [fhau_pkg::CNT_W-1:0] div_dsr, mul_mult;
    logic [15:0]                mul_add;
    logic [5:0]                 pkg_v;
    logic [3:0]                 die_v, plane_v;
    logic [15:0]                block_v;
    logic [9:0]                 page_v;
    logic [2:0]                 lv_in, both, cmp_level;

    fhau_pkg::t_div_out div_res;
    fhau_pkg::t_mul_out mul_res;

    always_comb begin
        np = fhau_pkg::eff_count(17'(r_pages_per_block), fhau_pkg::MAX_PAGES_PER_BLOCK);
        nb = fhau_pkg::eff_count(r_blocks_per_plane, fhau_pkg::MAX_BLOCKS_PER_PLANE);
        nl = fhau_pkg::eff_count(17'(r_planes_per_die), fhau_pkg::MAX_PLANES_PER_DIE);
        nd = fhau_pkg::eff_count(17'(r_dies_per_package), fhau_pkg::MAX_DIES_PER_PACKAGE);
        nk = fhau_pkg::eff_count(17'(r_packages_per_drive), fhau_pkg::MAX_PACKAGES);

        // only valid levels enter composition
        pkg_v   = (r_held_level >= fhau_pkg::LVL_PACKAGE) ? r_held_package : '0;
        die_v   = (r_held_level >= fhau_pkg::LVL_DIE)     ? r_held_die     : '0;
        plane_v = (r_held_level >= fhau_pkg::LVL_PLANE)   ? r_held_plane   : '0;
        block_v = (r_held_level >= fhau_pkg::LVL_BLOCK)   ? r_held_block   : '0;
        page_v  = (r_held_level >= fhau_pkg::LVL_PAGE)    ? r_held_page    : '0;

        case (r_stage)
            3'd0:    div_dsr = np;
            3'd1:    div_dsr = nb;
            3'd2:    div_dsr = nl;
            3'd3:    div_dsr = nd;
            default: div_dsr = nk;
        endcase

        // Horner order: package, then die, plane, block, page
        case (r_stage)
            3'd0: begin
                mul_mult = nd;
                mul_add  = 16'(die_v);
            end
            3'd1: begin
                mul_mult = nl;
                mul_add  = 16'(plane_v);
            end
            3'd2: begin
                mul_mult = nb;
                mul_add  = block_v;
            end
            default: begin
                mul_mult = np;
                mul_add  = 16'(page_v);
            end
        endcase

        lv_in     = fhau_pkg::clamp_level(i_level);
        both      = (r_held_level < lv_in) ? r_held_level : lv_in;
        cmp_level = fhau_pkg::LVL_NONE;
        if (both >= fhau_pkg::LVL_PACKAGE && r_held_package == i_package_in) begin
            cmp_level = fhau_pkg::LVL_PACKAGE;
            if (both >= fhau_pkg::LVL_DIE && r_held_die == i_die_in) begin
                cmp_level = fhau_pkg::LVL_DIE;
                if (both >= fhau_pkg::LVL_PLANE && r_held_plane == i_plane_in) begin
                    cmp_level = fhau_pkg::LVL_PLANE;
                    if (both >= fhau_pkg::LVL_BLOCK && r_held_block == i_block_in) begin
                        cmp_level = fhau_pkg::LVL_BLOCK;
                        if (both >= fhau_pkg::LVL_PAGE && r_held_page == i_page_in) begin
                            cmp_level = fhau_pkg::LVL_PAGE;
                        end
                    end
                end
            end
        end
    end

    fhau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_lin),
        .i_divisor  (div_dsr),
        .o_res      (div_res)
    );

    fhau_multiplier u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mul_start),
        .i_mcand  (r_acc),
        .i_mult   (mul_mult),
        .i_addend (mul_add),
        .o_res    (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_per_block    <= 11'd64;
            r_blocks_per_plane   <= 17'd2048;
            r_planes_per_die     <= 5'd1;
            r_dies_per_package   <= 5'd1;
            r_packages_per_drive <= 7'd1;
            r_held_package       <= '0;
            r_held_die           <= '0;
            r_held_plane         <= '0;
            r_held_block         <= '0;
            r_held_page          <= '0;
            r_held_level         <= fhau_pkg::LVL_NONE;
            r_state              <= S_IDLE;
            r_stage              <= '0;
            r_div_start          <= 1'b0;
            r_mul_start          <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_mul_start <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fhau_pkg::REG_PAGES_PER_BLOCK:  r_pages_per_block    <= i_cfg_data[10:0];
                    fhau_pkg::REG_BLOCKS_PER_PLANE: r_blocks_per_plane   <= i_cfg_data;
                    fhau_pkg::REG_PLANES_PER_DIE:   r_planes_per_die     <= i_cfg_data[4:0];
                    fhau_pkg::REG_DIES_PER_PACKAGE: r_dies_per_package   <= i_cfg_data[4:0];
                    fhau_pkg::REG_PACKAGES:         r_packages_per_drive <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_match <= (i_opcode == fhau_pkg::OP_COMPARE) ?
                                   cmp_level : fhau_pkg::LVL_NONE;
                        case (i_opcode)
                            fhau_pkg::OP_LOAD_LINEAR: begin
                                r_lin       <= i_linear_address;
                                r_lvl       <= lv_in;
                                r_stage     <= '0;
                                r_div_start <= 1'b1;
                                r_state     <= S_DIV;
                            end
                            fhau_pkg::OP_LOAD_FIELDS: begin
                                r_held_package <= i_package_in;
                                r_held_die     <= i_die_in;
                                r_held_plane   <= i_plane_in;
                                r_held_block   <= i_block_in;
                                r_held_page    <= i_page_in;
                                r_held_level   <= lv_in;
                                r_state        <= S_MINIT;
                            end
                            default: begin
                                r_state <= S_MINIT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_lin <= div_res.quotient;
                        case (r_stage)
                            3'd0:    r_held_page  <= div_res.remainder[9:0];
                            3'd1:    r_held_block <= div_res.remainder[15:0];
                            3'd2:    r_held_plane <= div_res.remainder[3:0];
                            3'd3:    r_held_die   <= div_res.remainder[3:0];
                            default: r_held_package <= div_res.remainder[5:0];
                        endcase
                        if (r_stage == DIV_LAST) begin
                            r_held_level <= r_lvl;
                            r_state      <= S_MINIT;
                        end else begin
                            r_stage     <= r_stage + 3'd1;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_MINIT: begin
                    r_acc       <= 40'(pkg_v);
                    r_stage     <= '0;
                    r_mul_start <= 1'b1;
                    r_state     <= S_MUL;
                end
                S_MUL: begin
                    if (mul_res.done) begin
                        r_acc <= mul_res.result;
                        if (r_stage == MUL_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_stage     <= r_stage + 3'd1;
                            r_mul_start <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_package <= r_held_package;
                        r_out_die     <= r_held_die;
                        r_out_plane   <= r_held_plane;
                        r_out_block   <= r_held_block;
                        r_out_page    <= r_held_page;
                        r_out_level   <= r_held_level;
                        r_out_addr    <= r_acc;
                        r_out_match   <= r_match;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_package_out      = r_out_package;
    assign o_die_out          = r_out_die;
    assign o_plane_out        = r_out_plane;
    assign o_block_out        = r_out_block;
    assign o_page_out         = r_out_page;
    assign o_level_out        = r_out_level;
    assign o_composed_address = r_out_addr;
    assign o_match_level      = r_out_match;

endmodule

// ----- sv/fhau_checker.sv -----
// ============================================================================
// fhau_checker
// Port-level checks for the flash hierarchical address unit.
// ============================================================================
module fhau_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  o_package_out,
    input  logic [3:0]  o_die_out,
    input  logic [3:0]  o_plane_out,
    input  logic [15:0] o_block_out,
    input  logic [9:0]  o_page_out,
    input  logic [2:0]  o_level_out,
    input  logic [39:0] o_composed_address,
    input  logic [2:0]  o_match_level
);

    // one operation in flight: an accepted transaction drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after a transaction");

    // a result never comes out in the cycle right after acceptance
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result appeared without any work");

    // stored level is clamped, and a match never runs deeper than it
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level_out <= fhau_pkg::LVL_PAGE && o_match_level <= o_level_out))
        else $error("level or match level out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_package_out) && $stable(o_die_out)
             && $stable(o_plane_out) && $stable(o_block_out) && $stable(o_page_out)
             && $stable(o_level_out) && $stable(o_composed_address)
             && $stable(o_match_level)))
        else $error("stalled result changed");

endmodule

bind flash_hierarchical_address_unit fhau_checker u_fhau_checker (.*);

// ----- test/fhau_result_checker.sv -----
// ============================================================================
// fhau_result_checker
// Watches the ports of the flash hierarchical address unit. It mirrors the
// geometry registers and the stored address, works out the expected result of
// every accepted operation and compares each returned transaction against it
// field by field.
// ============================================================================
module fhau_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [39:0] i_linear_address,
    input  logic [2:0]  i_level,
    input  logic [5:0]  i_package_in,
    input  logic [3:0]  i_die_in,
    input  logic [3:0]  i_plane_in,
    input  logic [15:0] i_block_in,
    input  logic [9:0]  i_page_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [5:0]  i_package_out,
    input  logic [3:0]  i_die_out,
    input  logic [3:0]  i_plane_out,
    input  logic [15:0] i_block_out,
    input  logic [9:0]  i_page_out,
    input  logic [2:0]  i_level_out,
    input  logic [39:0] i_composed_address,
    input  logic [2:0]  i_match_level,
    output int          o_outstanding,
    output int          o_fail_count
);

    typedef struct packed {
        logic [5:0]  pkg;
        logic [3:0]  die;
        logic [3:0]  plane;
        logic [15:0] blk;
        logic [9:0]  page;
        logic [2:0]  lvl;
        logic [39:0] flat;
        logic [2:0]  hit_lvl;
    } t_addr_result;

    // geometry registers as written (register width, before clipping)
    logic [10:0] geo_pages;
    logic [16:0] geo_blocks;
    logic [4:0]  geo_planes;
    logic [4:0]  geo_dies;
    logic [6:0]  geo_pkgs;

    logic [5:0]  held_pkg;
    logic [3:0]  held_die;
    logic [3:0]  held_plane;
    logic [15:0] held_blk;
    logic [9:0]  held_page;
    logic [2:0]  held_lvl;

    t_addr_result expected_results[$];
    int           fails = 0;

    function automatic logic [63:0] usable_count(input logic [16:0] raw,
                                                 input logic [16:0] ceiling);
        if (raw == '0) begin
            return 64'd1;
        end
        return (raw > ceiling) ? 64'(ceiling) : 64'(raw);
    endfunction

    function automatic void geometry_spans(output logic [63:0] np, output logic [63:0] nb,
                                           output logic [63:0] nl, output logic [63:0] nd,
                                           output logic [63:0] nk);
        np = usable_count(17'(geo_pages), fhau_pkg::MAX_PAGES_PER_BLOCK);
        nb = usable_count(geo_blocks, fhau_pkg::MAX_BLOCKS_PER_PLANE);
        nl = usable_count(17'(geo_planes), fhau_pkg::MAX_PLANES_PER_DIE);
        nd = usable_count(17'(geo_dies), fhau_pkg::MAX_DIES_PER_PACKAGE);
        nk = usable_count(17'(geo_pkgs), fhau_pkg::MAX_PACKAGES);
    endfunction

    // flat page number of the held address, valid levels only, 40-bit wrap
    function automatic logic [39:0] held_flat();
        logic [63:0] np, nb, nl, nd, nk, acc;
        geometry_spans(np, nb, nl, nd, nk);
        acc = '0;
        if (held_lvl >= fhau_pkg::LVL_PAGE)    acc += 64'(held_page);
        if (held_lvl >= fhau_pkg::LVL_BLOCK)   acc += np * 64'(held_blk);
        if (held_lvl >= fhau_pkg::LVL_PLANE)   acc += np * nb * 64'(held_plane);
        if (held_lvl >= fhau_pkg::LVL_DIE)     acc += np * nb * nl * 64'(held_die);
        if (held_lvl >= fhau_pkg::LVL_PACKAGE) acc += np * nb * nl * nd * 64'(held_pkg);
        return acc[39:0];
    endfunction

    function automatic t_addr_result apply_address_op(
        input logic [1:0] op, input logic [39:0] flat, input logic [2:0] lvl_raw,
        input logic [5:0] pk, input logic [3:0] di, input logic [3:0] pl,
        input logic [15:0] bl, input logic [9:0] pg);
        logic [63:0]  np, nb, nl, nd, nk, rest;
        logic [2:0]   lvl, shared;
        t_addr_result r;
        lvl = (lvl_raw > fhau_pkg::LVL_PAGE) ? fhau_pkg::LVL_PAGE : lvl_raw;
        r = '0;
        r.hit_lvl = fhau_pkg::LVL_NONE;
        case (op)
            fhau_pkg::OP_LOAD_LINEAR: begin
                geometry_spans(np, nb, nl, nd, nk);
                rest       = 64'(flat);
                held_page  = 10'(rest % np);
                rest       = rest / np;
                held_blk   = 16'(rest % nb);
                rest       = rest / nb;
                held_plane = 4'(rest % nl);
                rest       = rest / nl;
                held_die   = 4'(rest % nd);
                rest       = rest / nd;
                held_pkg   = 6'(rest % nk);
                held_lvl   = lvl;
            end
            fhau_pkg::OP_LOAD_FIELDS: begin
                held_pkg   = pk;
                held_die   = di;
                held_plane = pl;
                held_blk   = bl;
                held_page  = pg;
                held_lvl   = lvl;
            end
            fhau_pkg::OP_COMPARE: begin
                shared = (held_lvl < lvl) ? held_lvl : lvl;
                // walk down from package, stop at the first level that differs
                if (shared >= fhau_pkg::LVL_PACKAGE && held_pkg == pk) begin
                    r.hit_lvl = fhau_pkg::LVL_PACKAGE;
                    if (shared >= fhau_pkg::LVL_DIE && held_die == di) begin
                        r.hit_lvl = fhau_pkg::LVL_DIE;
                        if (shared >= fhau_pkg::LVL_PLANE && held_plane == pl) begin
                            r.hit_lvl = fhau_pkg::LVL_PLANE;
                            if (shared >= fhau_pkg::LVL_BLOCK && held_blk == bl) begin
                                r.hit_lvl = fhau_pkg::LVL_BLOCK;
                                if (shared >= fhau_pkg::LVL_PAGE && held_page == pg) begin
                                    r.hit_lvl = fhau_pkg::LVL_PAGE;
                                end
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        r.pkg   = held_pkg;
        r.die   = held_die;
        r.plane = held_plane;
        r.blk   = held_blk;
        r.page  = held_page;
        r.lvl   = held_lvl;
        r.flat  = held_flat();
        return r;
    endfunction

    function automatic string describe(input t_addr_result r);
        return $sformatf({"pkg %0d die %0d plane %0d blk %0d page %0d lvl %0d",
                          " flat 0x%010h hit %0d"},
                         r.pkg, r.die, r.plane, r.blk, r.page, r.lvl, r.flat, r.hit_lvl);
    endfunction

    always @(posedge i_clk) begin : watch
        t_addr_result want, got;
        logic         bad;
        if (!i_rst_n) begin
            geo_pages  <= 11'd64;
            geo_blocks <= 17'd2048;
            geo_planes <= 5'd1;
            geo_dies   <= 5'd1;
            geo_pkgs   <= 7'd1;
            held_pkg   = '0;
            held_die   = '0;
            held_plane = '0;
            held_blk   = '0;
            held_page  = '0;
            held_lvl   = fhau_pkg::LVL_NONE;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_package_out, i_die_out, i_plane_out, i_block_out, i_page_out,
                        i_level_out, i_composed_address, i_match_level};
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("[%0t] unexpected result transaction: %s", $realtime,
                                 describe(got));
                    end
                end else begin
                    want = expected_results.pop_front();
                    bad = (got.pkg !== want.pkg) || (got.die !== want.die)
                       || (got.plane !== want.plane) || (got.blk !== want.blk)
                       || (got.page !== want.page) || (got.lvl !== want.lvl)
                       || (got.flat !== want.flat) || (got.hit_lvl !== want.hit_lvl);
                    if (bad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] result mismatch", $realtime);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fhau_pkg::REG_PAGES_PER_BLOCK:  geo_pages  <= i_cfg_data[10:0];
                    fhau_pkg::REG_BLOCKS_PER_PLANE: geo_blocks <= i_cfg_data;
                    fhau_pkg::REG_PLANES_PER_DIE:   geo_planes <= i_cfg_data[4:0];
                    fhau_pkg::REG_DIES_PER_PACKAGE: geo_dies   <= i_cfg_data[4:0];
                    fhau_pkg::REG_PACKAGES:         geo_pkgs   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(apply_address_op(i_opcode, i_linear_address,
                    i_level, i_package_in, i_die_in, i_plane_in, i_block_in, i_page_in));
            end
        end
        o_outstanding <= expected_results.size();
        o_fail_count  <= fails;
    end

endmodule

// ----- test/tb.sv -----
// ============================================================================
// tb
// Regression for the flash hierarchical address unit. Runs directed corner
// operations, then bursty random sequences (loads followed by probing
// compares and read-backs, or single random operations) under a series of
// geometry settings, with random output stalls and one long output hold-off.
// Results are checked by fhau_result_checker.
// ============================================================================
module tb;

    localparam int unsigned LIMIT_CYCLES     = 3_000_000;
    localparam int          RANDOM_ITEMS     = 1750;
    localparam int          PHASES           = 9;
    localparam int          LONG_HOLD_AFTER  = 500;
    localparam int          LONG_HOLD_CYCLES = 800;
    localparam int          DRAIN_CYCLES     = 400;
    localparam logic [2:0]  REG_SPARE_LO     = 3'd5;  // first index past the register list
    localparam logic [2:0]  LVL_OVER         = 3'd7;

    typedef struct packed {
        logic [5:0]  pk;
        logic [3:0]  di;
        logic [3:0]  pl;
        logic [15:0] bl;
        logic [9:0]  pg;
    } t_addr_fields;

    localparam t_addr_fields FIELDS_ZERO = '0;
    localparam t_addr_fields FIELDS_ONES = '1;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic [2:0]  i_cfg_idx        = '0;
    logic [16:0] i_cfg_data       = '0;
    logic        i_in_valid       = 1'b0;
    logic [1:0]  i_opcode         = fhau_pkg::OP_READ_LINEAR;
    logic [39:0] i_linear_address = '0;
    logic [2:0]  i_level          = fhau_pkg::LVL_NONE;
    logic [5:0]  i_package_in     = '0;
    logic [3:0]  i_die_in         = '0;
    logic [3:0]  i_plane_in       = '0;
    logic [15:0] i_block_in       = '0;
    logic [9:0]  i_page_in        = '0;
    logic        i_out_ready      = 1'b0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [5:0]  o_package_out;
    logic [3:0]  o_die_out;
    logic [3:0]  o_plane_out;
    logic [15:0] o_block_out;
    logic [9:0]  o_page_out;
    logic [2:0]  o_level_out;
    logic [39:0] o_composed_address;
    logic [2:0]  o_match_level;

    int outstanding;
    int fail_count;
    int ops_sent [4] = '{0, 0, 0, 0};
    int burst_left   = 1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    flash_hierarchical_address_unit dut (.*);

    fhau_result_checker checker_i (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_linear_address   (i_linear_address),
        .i_level            (i_level),
        .i_package_in       (i_package_in),
        .i_die_in           (i_die_in),
        .i_plane_in         (i_plane_in),
        .i_block_in         (i_block_in),
        .i_page_in          (i_page_in),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_package_out      (o_package_out),
        .i_die_out          (o_die_out),
        .i_plane_out        (o_plane_out),
        .i_block_out        (o_block_out),
        .i_page_out         (o_page_out),
        .i_level_out        (o_level_out),
        .i_composed_address (o_composed_address),
        .i_match_level      (o_match_level),
        .o_outstanding      (outstanding),
        .o_fail_count       (fail_count)
    );

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [15:0] pick_bits(input int w);
        logic [15:0] full;
        full = 16'((32'd1 << w) - 1);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return full;
            2, 3:    return 16'($urandom_range(0, 3)) & full;
            default: return 16'($urandom) & full;
        endcase
    endfunction

    function automatic t_addr_fields pick_fields();
        t_addr_fields f;
        f.pk = 6'(pick_bits(6));
        f.di = 4'(pick_bits(4));
        f.pl = 4'(pick_bits(4));
        f.bl = pick_bits(16);
        f.pg = 10'(pick_bits(10));
        return f;
    endfunction

    function automatic logic [39:0] pick_flat();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 40'($urandom_range(0, 4095));
            3:       return 40'($urandom);
            default: return {8'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [2:0] pick_level();
        if ($urandom_range(0, 2) == 0) begin
            return 3'($urandom_range(0, 7));
        end
        return 3'($urandom_range(fhau_pkg::LVL_BLOCK, LVL_OVER));
    endfunction

    function automatic logic [16:0] mixed_count(input int hi);
        if ($urandom_range(0, 1) == 0) begin
            return 17'($urandom_range(1, hi));
        end
        return 17'($urandom);
    endfunction

    // one input transaction; bursts end with a random gap
    task automatic issue_op(input logic [1:0] op, input logic [39:0] flat,
                            input logic [2:0] lvl, input t_addr_fields f);
        int gap;
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_linear_address <= flat;
        i_level          <= lvl;
        i_package_in     <= f.pk;
        i_die_in         <= f.di;
        i_plane_in       <= f.pl;
        i_block_in       <= f.bl;
        i_page_in        <= f.pg;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        ops_sent[op]++;
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 30);
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [16:0] pages, input logic [16:0] blocks,
                                  input logic [16:0] planes, input logic [16:0] dies,
                                  input logic [16:0] pkgs);
        logic [16:0] vals [5];
        logic [2:0]  regs [5];
        vals = '{pages, blocks, planes, dies, pkgs};
        regs = '{fhau_pkg::REG_PAGES_PER_BLOCK, fhau_pkg::REG_BLOCKS_PER_PLANE,
                 fhau_pkg::REG_PLANES_PER_DIE, fhau_pkg::REG_DIES_PER_PACKAGE,
                 fhau_pkg::REG_PACKAGES};
        // a write past the register list must be ignored
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SPARE_LO + 3'($urandom_range(0, 2));
        i_cfg_data <= 17'($urandom);
        @(posedge i_clk);
        for (int i = 0; i < 5; i++) begin
            i_cfg_idx  <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        t_addr_fields g;
        issue_op(fhau_pkg::OP_READ_LINEAR, '0, fhau_pkg::LVL_NONE, FIELDS_ZERO);
        // stored level none
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, FIELDS_ZERO);
        issue_op(fhau_pkg::OP_LOAD_FIELDS, '0, fhau_pkg::LVL_PAGE, FIELDS_ONES);
        // fields beyond counts
        issue_op(fhau_pkg::OP_READ_LINEAR, '1, fhau_pkg::LVL_NONE, FIELDS_ZERO);
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, FIELDS_ONES);
        // level above page
        issue_op(fhau_pkg::OP_COMPARE, '0, LVL_OVER, FIELDS_ONES);
        // differ one level shallower each time
        g = FIELDS_ONES;
        g.pg = '0;
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, g);
        g.bl = '0;
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, g);
        g.pl = '0;
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, g);
        g.di = '0;
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, g);
        g.pk = '0;
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, g);
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PLANE, FIELDS_ONES);
        issue_op(fhau_pkg::OP_LOAD_FIELDS, '0, fhau_pkg::LVL_PAGE + 3'd1, FIELDS_ONES);
        issue_op(fhau_pkg::OP_LOAD_FIELDS, '0, fhau_pkg::LVL_DIE, FIELDS_ONES);
        issue_op(fhau_pkg::OP_COMPARE, '0, fhau_pkg::LVL_PAGE, FIELDS_ONES);
        issue_op(fhau_pkg::OP_READ_LINEAR, '0, fhau_pkg::LVL_PAGE, FIELDS_ZERO);
        issue_op(fhau_pkg::OP_LOAD_FIELDS, '0, fhau_pkg::LVL_NONE, FIELDS_ONES);
        issue_op(fhau_pkg::OP_READ_LINEAR, '0, fhau_pkg::LVL_NONE, FIELDS_ZERO);
        issue_op(fhau_pkg::OP_LOAD_LINEAR, '0, fhau_pkg::LVL_PAGE, FIELDS_ONES);
        issue_op(fhau_pkg::OP_LOAD_LINEAR, '1, fhau_pkg::LVL_PAGE, FIELDS_ZERO);
        issue_op(fhau_pkg::OP_LOAD_LINEAR, 40'd1234567, fhau_pkg::LVL_PLANE, FIELDS_ZERO);
        issue_op(fhau_pkg::OP_LOAD_LINEAR, {8'($urandom), 32'($urandom)}, LVL_OVER,
                 FIELDS_ZERO);
        issue_op(fhau_pkg::OP_READ_LINEAR, '0, fhau_pkg::LVL_NONE, FIELDS_ONES);
    endtask

    task automatic run_sequence(output int issued);
        t_addr_fields f, g;
        int           kind, reps;
        issued = 0;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            // load an address, then probe it with compares that diverge at one level or not at all
            f = pick_fields();
            issue_op(fhau_pkg::OP_LOAD_FIELDS, pick_flat(), pick_level(), f);
            issued++;
            reps = $urandom_range(1, 4);
            for (int k = 0; k < reps; k++) begin
                g = f;
                case ($urandom_range(0, 5))
                    0: g.pk ^= 6'($urandom_range(1, 63));
                    1: g.di ^= 4'($urandom_range(1, 15));
                    2: g.pl ^= 4'($urandom_range(1, 15));
                    3: g.bl ^= 16'($urandom_range(1, 65535));
                    4: g.pg ^= 10'($urandom_range(1, 1023));
                    default: ;
                endcase
                issue_op(fhau_pkg::OP_COMPARE, pick_flat(), pick_level(), g);
                issued++;
            end
            if ($urandom_range(0, 1) == 1) begin
                issue_op(fhau_pkg::OP_READ_LINEAR, pick_flat(), pick_level(), pick_fields());
                issued++;
            end
        end else if (kind < 7) begin
            issue_op(fhau_pkg::OP_LOAD_LINEAR, pick_flat(), pick_level(), pick_fields());
            issue_op(fhau_pkg::OP_READ_LINEAR, pick_flat(), pick_level(), pick_fields());
            issued += 2;
            if ($urandom_range(0, 2) == 0) begin
                issue_op(fhau_pkg::OP_COMPARE, pick_flat(), pick_level(), pick_fields());
                issued++;
            end
        end else begin
            issue_op(2'($urandom_range(0, 3)), pick_flat(), 3'($urandom_range(0, 7)),
                     pick_fields());
            issued++;
        end
    endtask

    // ---------------------------------------------------------------- result side

    initial begin : result_sink
        int outs_seen, run, mode;
        bit long_done;
        outs_seen = 0;
        long_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            run  = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            for (int c = 0; c < run; c++) begin
                // one long hold-off so the unit backs up into its input
                if (!long_done && outs_seen >= LONG_HOLD_AFTER) begin
                    long_done = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0:       i_out_ready <= 1'b1;
                    1:       i_out_ready <= (c >= 10);
                    default: i_out_ready <= ($urandom_range(0, 9) < 6);
                endcase
                @(posedge i_clk);
                if (o_out_valid && i_out_ready) outs_seen++;
            end
        end
    end

    // ---------------------------------------------------------------- main flow

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int per_phase, done_in_phase, issued, total;
        per_phase = RANDOM_ITEMS / PHASES;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                i_in_valid <= 1'b0;
                drain();
                case (p)
                    1:       write_geometry(17'd1, 17'd1, 17'd1, 17'd1, 17'd1);
                    2:       write_geometry(17'd1024, 17'd65536, 17'd16, 17'd16, 17'd64);
                    3:       write_geometry('0, '0, '0, '0, '0);
                    4:       write_geometry('1, '1, '1, '1, '1);
                    5, 7:    write_geometry(17'($urandom_range(1, 8)),
                                            17'($urandom_range(1, 8)),
                                            17'($urandom_range(1, 4)),
                                            17'($urandom_range(1, 4)),
                                            17'($urandom_range(1, 5)));
                    default: write_geometry(mixed_count(1024), mixed_count(65536),
                                            mixed_count(16), mixed_count(16),
                                            mixed_count(64));
                endcase
            end
            done_in_phase = 0;
            while (done_in_phase < per_phase) begin
                run_sequence(issued);
                done_in_phase += issued;
            end
        end
        i_in_valid <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        total = ops_sent[fhau_pkg::OP_LOAD_LINEAR] + ops_sent[fhau_pkg::OP_LOAD_FIELDS]
              + ops_sent[fhau_pkg::OP_READ_LINEAR] + ops_sent[fhau_pkg::OP_COMPARE];
        $display("Covered %0d operations: %0d load linear, %0d load fields, %0d read linear,",
                 total, ops_sent[fhau_pkg::OP_LOAD_LINEAR],
                 ops_sent[fhau_pkg::OP_LOAD_FIELDS], ops_sent[fhau_pkg::OP_READ_LINEAR]);
        $display("%0d compare, across %0d geometry settings with output back-pressure",
                 ops_sent[fhau_pkg::OP_COMPARE], PHASES);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- flash_hierarchical_address_unit.f -----
sv/fhau_pkg.sv
sv/fhau_divider.sv
sv/fhau_multiplier.sv
sv/flash_hierarchical_address_unit.sv
sv/fhau_checker.sv
test/fhau_result_checker.sv
test/tb.sv
